// ===== rtl/qdc_pkg.sv =====
// Shared types and constants of the charge histogram core.
package qdc_pkg;

   localparam int MAX_BINS   = 4096;
   localparam int MAX_WINDOW = 1024;
   localparam int SAMPLE_W   = 12;
   localparam int CHARGE_W   = 22;
   localparam int BINS_W     = 17;
   localparam int DVD_W      = 40;
   localparam int DVS_W      = 22;
   localparam int CNT_W      = 32;

   localparam logic [SAMPLE_W-1:0] SAMPLE_FULL = '1;

   // request codes
   typedef enum logic [1:0] {
      REQ_SAMPLE = 2'd0,
      REQ_READ   = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_NONE   = 2'd3
   } req_type_type;

   // result codes
   typedef enum logic [2:0] {
      KIND_BINNED    = 3'd0,
      KIND_OUT_RANGE = 3'd1,
      KIND_HIGH_CLIP = 3'd2,
      KIND_LOW_CLIP  = 3'd3,
      KIND_BIN_READ  = 3'd4
   } kind_type;

   // register indexes
   typedef enum logic [2:0] {
      REG_WINDOW   = 3'd0,
      REG_BASELINE = 3'd1,
      REG_MIN      = 3'd2,
      REG_MAX      = 3'd3,
      REG_BINS     = 3'd4
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_VERDICT,
      ST_DIV_B_GO,
      ST_DIV_B_WAIT,
      ST_SCALE,
      ST_DIV_Q_GO,
      ST_DIV_Q_WAIT,
      ST_HIST_RD,
      ST_HIST_WR,
      ST_RD_ADDR,
      ST_RD_DATA,
      ST_RESP
   } state_type;

   // divider status towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== rtl/qdc_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module qdc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [qdc_pkg::DVD_W-1:0]   dividend,
   input  logic [qdc_pkg::DVS_W-1:0]   divisor,
   output logic [qdc_pkg::DVD_W-1:0]   quotient,
   output qdc_pkg::div_status_type     status
);

   localparam int DVD_W = qdc_pkg::DVD_W;
   localparam int DVS_W = qdc_pkg::DVS_W;
   localparam int CW    = $clog2(DVD_W);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diffv;
   logic             ge;

   // one trial subtraction per cycle
   always_comb begin
      trial   = {rem_ff, quo_ff[DVD_W-1]};
      diffv   = trial - {1'b0, dvs_ff};
      ge      = trial >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diffv[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== rtl/qdc_hist.sv =====
// Histogram store: single port memory with registered read data.
module qdc_hist #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               addr,
   input  logic [qdc_pkg::CNT_W-1:0]   wr_data,
   output logic [qdc_pkg::CNT_W-1:0]   rd_data
);

   logic [qdc_pkg::CNT_W-1:0] mem [DEPTH];
   logic [qdc_pkg::CNT_W-1:0] rd_ff;

   // write and read the addressed bin
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_ff <= mem[addr];
   end

   assign rd_data = rd_ff;

endmodule

// ===== rtl/qdc_charge_histogram_core.sv =====
// Charge histogram core. Sample beats other than the last of a trace leave the core idle;
// the final one starts a verdict that runs up to two passes of the shared 40-step divider
// (baseline scaling, then binning), each after a multiply; clip verdicts skip it and a
// binned trace then bumps its bin. A bin read passes an address state and a data state.
// A clear request, a register write and reset sweep the histogram one bin per cycle and
// take no request meanwhile; the result register frees the request side while results wait.
module qdc_charge_histogram_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_type,
   input  logic [11:0]  req_sample,
   input  logic         req_last_of_trace,
   input  logic [15:0]  req_dither,
   input  logic [11:0]  req_bin_address,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [2:0]   rsp_kind,
   output logic [21:0]  rsp_charge,
   output logic [11:0]  rsp_bin_index,
   output logic [31:0]  rsp_bin_count,
   output logic [31:0]  rsp_high_clip_total,
   output logic [31:0]  rsp_low_clip_total,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [21:0]  csr_data
);

   localparam int AW     = $clog2(qdc_pkg::MAX_BINS);
   localparam int DVD_W  = qdc_pkg::DVD_W;
   localparam int CHG_W  = qdc_pkg::CHARGE_W;
   localparam int BINS_W = qdc_pkg::BINS_W;

   qdc_pkg::state_type      state_ff, state_in;
   qdc_pkg::div_status_type div_st;

   logic [10:0]        win_ff, win_in, bpt_ff, bpt_in;
   logic [21:0]        minv_ff, minv_in, maxv_ff, maxv_in;
   logic [12:0]        bins_ff, bins_in;
   logic [11:0]        pos_ff, pos_in;
   logic [21:0]        bsum_ff, bsum_in, wsum_ff, wsum_in;
   logic [1:0]         fs_ff, fs_in, zh_ff, zh_in;
   logic               dec_ff, dec_in;
   logic [31:0]        hc_ff, hc_in, lc_ff, lc_in;
   logic [AW-1:0]      clr_ff, clr_in, addr_ff, addr_in, bin_ff, bin_in;
   logic               rdok_ff, rdok_in;
   logic [CHG_W-1:0]   charge_ff, charge_in;
   logic [DVD_W-1:0]   op_ff, op_in;
   logic [2:0]         res_kind_ff, res_kind_in;
   logic [CHG_W-1:0]   res_charge_ff, res_charge_in;
   logic [11:0]        res_idx_ff, res_idx_in;
   logic [31:0]        res_cnt_ff, res_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_kind_ff, rsp_kind_in;
   logic [21:0]        rsp_charge_ff, rsp_charge_in;
   logic [11:0]        rsp_idx_ff, rsp_idx_in;
   logic [31:0]        rsp_cnt_ff, rsp_cnt_in, rsp_hc_ff, rsp_hc_in, rsp_lc_ff, rsp_lc_in;

   logic [10:0]        w_use, p_use;
   logic [BINS_W-1:0]  bins_use;
   logic [21:0]        maxv_use;
   logic               div_start;
   logic [21:0]        div_dvs;
   logic [DVD_W-1:0]   quo;
   logic               mem_we;
   logic [AW-1:0]      mem_addr;
   logic [31:0]        mem_wdata, mem_rdata;
   logic [23:0]        diff, dmin;
   logic [DVD_W-1:0]   bin_val;
   logic               bin_ok;
   logic [16:0]        addr_ext;
   logic               cfg_hit;

   // clamp the registers to their usable ranges
   always_comb begin
      w_use = (win_ff == '0) ? 11'd1 :
              (win_ff > 11'(qdc_pkg::MAX_WINDOW)) ? 11'(qdc_pkg::MAX_WINDOW) : win_ff;
      p_use = (bpt_ff == '0) ? 11'd1 :
              (bpt_ff > 11'(qdc_pkg::MAX_WINDOW)) ? 11'(qdc_pkg::MAX_WINDOW) : bpt_ff;
      bins_use = (bins_ff == '0) ? BINS_W'(1) :
                 (BINS_W'(bins_ff) > BINS_W'(qdc_pkg::MAX_BINS)) ? BINS_W'(qdc_pkg::MAX_BINS)
                                                                 : BINS_W'(bins_ff);
      maxv_use = (maxv_ff == '0) ? 22'd1 : maxv_ff;
   end

   // sequencer: next state, trace update and result assembly
   always_comb begin
      state_in      = state_ff;
      win_in        = win_ff;
      bpt_in        = bpt_ff;
      minv_in       = minv_ff;
      maxv_in       = maxv_ff;
      bins_in       = bins_ff;
      pos_in        = pos_ff;
      bsum_in       = bsum_ff;
      wsum_in       = wsum_ff;
      fs_in         = fs_ff;
      zh_in         = zh_ff;
      dec_in        = dec_ff;
      hc_in         = hc_ff;
      lc_in         = lc_ff;
      clr_in        = clr_ff;
      addr_in       = addr_ff;
      bin_in        = bin_ff;
      rdok_in       = rdok_ff;
      charge_in     = charge_ff;
      op_in         = op_ff;
      res_kind_in   = res_kind_ff;
      res_charge_in = res_charge_ff;
      res_idx_in    = res_idx_ff;
      res_cnt_in    = res_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_charge_in = rsp_charge_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_hc_in     = rsp_hc_ff;
      rsp_lc_in     = rsp_lc_ff;
      req_stall     = 1'b1;
      div_start     = 1'b0;
      div_dvs       = maxv_use;
      mem_we        = 1'b0;
      mem_addr      = bin_ff;
      mem_wdata     = '0;
      diff          = {2'b0, charge_ff} - {1'b0, quo[22:0]};
      dmin          = {2'b0, charge_ff} - {2'b0, minv_ff};
      bin_val       = quo - DVD_W'(dec_ff);
      bin_ok        = (bin_val != '0) && !(dec_ff && quo == '0)
                      && (bin_val < DVD_W'(bins_use));
      addr_ext      = 17'(req_bin_address);

      case (state_ff)
         qdc_pkg::ST_CLEAR: begin
            // sweep the histogram to zero
            mem_we   = 1'b1;
            mem_addr = clr_ff;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == AW'(qdc_pkg::MAX_BINS - 1)) begin
               state_in = qdc_pkg::ST_IDLE;
            end
         end
         qdc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               case (req_type)
                  qdc_pkg::REQ_SAMPLE: begin
                     if (pos_ff < 12'(p_use)) begin
                        bsum_in = bsum_ff + 22'(req_sample);
                     end else if (pos_ff < 12'(p_use) + 12'(w_use)) begin
                        wsum_in = wsum_ff + 22'(req_sample);
                        if (req_sample == '0 && zh_ff != 2'd2) zh_in = zh_ff + 1'b1;
                        if (req_sample == qdc_pkg::SAMPLE_FULL && fs_ff != 2'd2) begin
                           fs_in = fs_ff + 1'b1;
                        end
                     end
                     if (pos_ff < 12'(2 * qdc_pkg::MAX_WINDOW)) pos_in = pos_ff + 1'b1;
                     if (req_last_of_trace) begin
                        dec_in   = !req_dither[15];
                        state_in = qdc_pkg::ST_VERDICT;
                     end
                  end
                  qdc_pkg::REQ_READ: begin
                     rdok_in    = addr_ext < 17'(qdc_pkg::MAX_BINS);
                     addr_in    = addr_ext[AW-1:0];
                     res_idx_in = req_bin_address;
                     state_in   = qdc_pkg::ST_RD_ADDR;
                  end
                  qdc_pkg::REQ_CLEAR: begin
                     hc_in    = '0;
                     lc_in    = '0;
                     clr_in   = '0;
                     state_in = qdc_pkg::ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         qdc_pkg::ST_VERDICT: begin
            // decide the trace, then drop it
            res_charge_in = '0;
            res_idx_in    = '0;
            res_cnt_in    = '0;
            charge_in     = wsum_ff;
            op_in         = DVD_W'(33'(bsum_ff) * 33'(w_use));
            pos_in        = '0;
            bsum_in       = '0;
            wsum_in       = '0;
            fs_in         = '0;
            zh_in         = '0;
            if (fs_ff > 2'd1) begin
               hc_in       = (hc_ff == '1) ? hc_ff : hc_ff + 1'b1;
               res_kind_in = qdc_pkg::KIND_HIGH_CLIP;
               state_in    = qdc_pkg::ST_RESP;
            end else if (zh_ff > 2'd1) begin
               lc_in       = (lc_ff == '1) ? lc_ff : lc_ff + 1'b1;
               res_kind_in = qdc_pkg::KIND_LOW_CLIP;
               state_in    = qdc_pkg::ST_RESP;
            end else begin
               state_in = qdc_pkg::ST_DIV_B_GO;
            end
         end
         qdc_pkg::ST_DIV_B_GO: begin
            div_start = 1'b1;
            div_dvs   = 22'(p_use);
            state_in  = qdc_pkg::ST_DIV_B_WAIT;
         end
         qdc_pkg::ST_DIV_B_WAIT: begin
            if (div_st.done) begin
               charge_in = diff[23] ? 22'(-diff) : diff[21:0];
               state_in  = qdc_pkg::ST_SCALE;
            end
         end
         qdc_pkg::ST_SCALE: begin
            res_charge_in = charge_ff;
            op_in         = DVD_W'(bins_use) * DVD_W'(dmin[22:0]);
            if (dmin[23]) begin
               res_kind_in = qdc_pkg::KIND_OUT_RANGE;
               state_in    = qdc_pkg::ST_RESP;
            end else begin
               state_in = qdc_pkg::ST_DIV_Q_GO;
            end
         end
         qdc_pkg::ST_DIV_Q_GO: begin
            div_start = 1'b1;
            state_in  = qdc_pkg::ST_DIV_Q_WAIT;
         end
         qdc_pkg::ST_DIV_Q_WAIT: begin
            if (div_st.done) begin
               bin_in = bin_val[AW-1:0];
               if (bin_ok) begin
                  res_idx_in = bin_val[11:0];
                  state_in   = qdc_pkg::ST_HIST_RD;
               end else begin
                  res_kind_in = qdc_pkg::KIND_OUT_RANGE;
                  state_in    = qdc_pkg::ST_RESP;
               end
            end
         end
         qdc_pkg::ST_HIST_RD: begin
            state_in = qdc_pkg::ST_HIST_WR;
         end
         qdc_pkg::ST_HIST_WR: begin
            // bump the bin, saturating
            mem_we      = 1'b1;
            mem_wdata   = (mem_rdata == '1) ? mem_rdata : mem_rdata + 1'b1;
            res_kind_in = qdc_pkg::KIND_BINNED;
            state_in    = qdc_pkg::ST_RESP;
         end
         qdc_pkg::ST_RD_ADDR: begin
            mem_addr = addr_ff;
            state_in = qdc_pkg::ST_RD_DATA;
         end
         qdc_pkg::ST_RD_DATA: begin
            res_kind_in   = qdc_pkg::KIND_BIN_READ;
            res_charge_in = '0;
            res_cnt_in    = rdok_ff ? mem_rdata : '0;
            state_in      = qdc_pkg::ST_RESP;
         end
         qdc_pkg::ST_RESP: begin
            // hand the beat to the result register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = res_kind_ff;
               rsp_charge_in = res_charge_ff;
               rsp_idx_in    = res_idx_ff;
               rsp_cnt_in    = res_cnt_ff;
               rsp_hc_in     = hc_ff;
               rsp_lc_in     = lc_ff;
               state_in      = qdc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = qdc_pkg::ST_IDLE;
         end
      endcase

      // register write: load, drop trace and spectrum, sweep
      cfg_hit = 1'b1;
      if (csr_valid) begin
         case (csr_index)
            qdc_pkg::REG_WINDOW:   win_in  = csr_data[10:0];
            qdc_pkg::REG_BASELINE: bpt_in  = csr_data[10:0];
            qdc_pkg::REG_MIN:      minv_in = csr_data;
            qdc_pkg::REG_MAX:      maxv_in = csr_data;
            qdc_pkg::REG_BINS:     bins_in = csr_data[12:0];
            default:               cfg_hit = 1'b0;
         endcase
         if (cfg_hit) begin
            pos_in   = '0;
            bsum_in  = '0;
            wsum_in  = '0;
            fs_in    = '0;
            zh_in    = '0;
            hc_in    = '0;
            lc_in    = '0;
            clr_in   = '0;
            state_in = qdc_pkg::ST_CLEAR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qdc_pkg::ST_CLEAR;
         win_ff       <= 11'd20;
         bpt_ff       <= 11'd10;
         minv_ff      <= '0;
         maxv_ff      <= 22'd100;
         bins_ff      <= 13'd4096;
         pos_ff       <= '0;
         bsum_ff      <= '0;
         wsum_ff      <= '0;
         fs_ff        <= '0;
         zh_ff        <= '0;
         hc_ff        <= '0;
         lc_ff        <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_ff       <= win_in;
         bpt_ff       <= bpt_in;
         minv_ff      <= minv_in;
         maxv_ff      <= maxv_in;
         bins_ff      <= bins_in;
         pos_ff       <= pos_in;
         bsum_ff      <= bsum_in;
         wsum_ff      <= wsum_in;
         fs_ff        <= fs_in;
         zh_ff        <= zh_in;
         hc_ff        <= hc_in;
         lc_ff        <= lc_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dec_ff        <= dec_in;
      addr_ff       <= addr_in;
      bin_ff        <= bin_in;
      rdok_ff       <= rdok_in;
      charge_ff     <= charge_in;
      op_ff         <= op_in;
      res_kind_ff   <= res_kind_in;
      res_charge_ff <= res_charge_in;
      res_idx_ff    <= res_idx_in;
      res_cnt_ff    <= res_cnt_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_charge_ff <= rsp_charge_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_hc_ff     <= rsp_hc_in;
      rsp_lc_ff     <= rsp_lc_in;
   end

   qdc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (op_ff),
      .divisor  (div_dvs),
      .quotient (quo),
      .status   (div_st)
   );

   qdc_hist #(
      .DEPTH (qdc_pkg::MAX_BINS),
      .AW    (AW)
   ) u_hist (
      .clock   (clock),
      .wr_en   (mem_we),
      .addr    (mem_addr),
      .wr_data (mem_wdata),
      .rd_data (mem_rdata)
   );

   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_charge          = rsp_charge_ff;
   assign rsp_bin_index       = rsp_idx_ff;
   assign rsp_bin_count       = rsp_cnt_ff;
   assign rsp_high_clip_total = rsp_hc_ff;
   assign rsp_low_clip_total  = rsp_lc_ff;

   // divider is never restarted mid-run
   assert property (@(posedge clock) disable iff (reset) div_start |-> !div_st.busy)
      else $error("divider started while busy");

   // a high clip beat carries a nonzero clip total
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == qdc_pkg::KIND_HIGH_CLIP) |-> rsp_high_clip_total != '0)
      else $error("high clip beat with zero total");

   // a new result beat only comes out of the response state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == qdc_pkg::ST_RESP)
      else $error("result beat raised outside response state");

endmodule

// ===== bench/tb_qdc_charge_histogram_core.sv =====
// Self-checking testbench of the charge histogram core: traces, bin reads, clears, registers.
`timescale 1ns / 100ps

module tb_qdc_charge_histogram_core;

   localparam int  N_BINS      = qdc_pkg::MAX_BINS;
   localparam int  N_REGS      = 5;
   localparam int  SETTLE      = 200;
   localparam longint LIMIT    = 2_000_000;
   localparam int  ITEM_TARGET = 1250;

   typedef struct {
      qdc_pkg::kind_type kind;
      logic [21:0] charge;
      logic [11:0] bin_index;
      logic [31:0] bin_count;
      logic [31:0] high_total;
      logic [31:0] low_total;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = qdc_pkg::REQ_NONE;
   logic [11:0] req_sample = '0;
   logic        req_last_of_trace = 1'b0;
   logic [15:0] req_dither = '0;
   logic [11:0] req_bin_address = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [21:0] rsp_charge;
   logic [11:0] rsp_bin_index;
   logic [31:0] rsp_bin_count;
   logic [31:0] rsp_high_clip_total;
   logic [31:0] rsp_low_clip_total;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = qdc_pkg::REG_WINDOW;
   logic [21:0] csr_data = '0;

   // expected verdicts and bin reads, oldest first
   verdict_type pending_verdicts[$];
   int          error_count = 0;
   longint      cycle_count = 0;
   int          beats_sent = 0;
   bit          calm = 1'b0;
   int          stall_left = 0;
   int          phase_len = 0;

   // shadow of the block: registers, trace in progress, spectrum
   logic [21:0]       reg_shadow[N_REGS];
   int unsigned       trace_pos;
   longint unsigned   base_acc;
   longint unsigned   window_acc;
   int unsigned       full_hits;
   int unsigned       zero_hits_m;
   logic [31:0]       spectrum[N_BINS];
   logic [31:0]       high_clips;
   logic [31:0]       low_clips;
   int unsigned       recent_bin = 1;

   qdc_charge_histogram_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_sample(req_sample), .req_last_of_trace(req_last_of_trace),
      .req_dither(req_dither), .req_bin_address(req_bin_address),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_charge(rsp_charge), .rsp_bin_index(rsp_bin_index),
      .rsp_bin_count(rsp_bin_count), .rsp_high_clip_total(rsp_high_clip_total),
      .rsp_low_clip_total(rsp_low_clip_total),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [31:0] bump(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   task automatic drop_trace();
      trace_pos   = 0;
      base_acc    = 0;
      window_acc  = 0;
      full_hits   = 0;
      zero_hits_m = 0;
   endtask

   task automatic wipe_spectrum();
      foreach (spectrum[i]) spectrum[i] = '0;
      high_clips = '0;
      low_clips  = '0;
   endtask

   task automatic queue_verdict(qdc_pkg::kind_type k, logic [21:0] q, logic [11:0] idx,
                                logic [31:0] cnt);
      verdict_type v;
      v.kind = k; v.charge = q; v.bin_index = idx; v.bin_count = cnt;
      v.high_total = high_clips; v.low_total = low_clips;
      pending_verdicts.push_back(v);
   endtask

   // advance the shadow by one accepted request beat
   task automatic predict_beat(logic [1:0] t, logic [11:0] s, logic last,
                               logic [15:0] dth, logic [11:0] addr);
      int unsigned     w, p, nbins, maxv;
      longint unsigned scaled_base, charge_abs;
      longint          diff, num, q, bin;
      case (t)
         qdc_pkg::REQ_CLEAR: wipe_spectrum();
         qdc_pkg::REQ_READ:  queue_verdict(qdc_pkg::KIND_BIN_READ, '0, addr, spectrum[addr]);
         qdc_pkg::REQ_SAMPLE: begin
            w = clamp(reg_shadow[qdc_pkg::REG_WINDOW], 1, qdc_pkg::MAX_WINDOW);
            p = clamp(reg_shadow[qdc_pkg::REG_BASELINE], 1, qdc_pkg::MAX_WINDOW);
            if (trace_pos < p) begin
               base_acc += s;
            end else if (trace_pos < p + w) begin
               window_acc += s;
               if (s == 0 && zero_hits_m < 2047) zero_hits_m++;
               if (s == qdc_pkg::SAMPLE_FULL && full_hits < 2047) full_hits++;
            end
            if (trace_pos < 2 * qdc_pkg::MAX_WINDOW) trace_pos++;
            if (last) begin
               if (full_hits > 1) begin
                  high_clips = bump(high_clips);
                  queue_verdict(qdc_pkg::KIND_HIGH_CLIP, '0, '0, '0);
               end else if (zero_hits_m > 1) begin
                  low_clips = bump(low_clips);
                  queue_verdict(qdc_pkg::KIND_LOW_CLIP, '0, '0, '0);
               end else begin
                  nbins = clamp(reg_shadow[qdc_pkg::REG_BINS], 1, N_BINS);
                  maxv  = (reg_shadow[qdc_pkg::REG_MAX] == 0) ? 1
                                                              : reg_shadow[qdc_pkg::REG_MAX];
                  scaled_base = base_acc * w / p;
                  diff = longint'(window_acc) - longint'(scaled_base);
                  charge_abs = (diff < 0) ? -diff : diff;
                  num = longint'(nbins) * (longint'(charge_abs)
                        - longint'(reg_shadow[qdc_pkg::REG_MIN]));
                  q   = num / longint'(maxv);
                  bin = (dth < 16'd32768) ? q - 1 : q;
                  if (bin > 0 && bin < nbins) begin
                     spectrum[bin[11:0]] = bump(spectrum[bin[11:0]]);
                     recent_bin = 32'(bin);
                     queue_verdict(qdc_pkg::KIND_BINNED, charge_abs[21:0], bin[11:0], '0);
                  end else begin
                     queue_verdict(qdc_pkg::KIND_OUT_RANGE, charge_abs[21:0], '0, '0);
                  end
               end
               drop_trace();
            end
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      $display("[%0d] mismatch %s: got %0d, expected %0d", cycle_count, what, got, want);
   endtask

   // check each result beat against the oldest expectation; stall in bursts
   always @(posedge clock) begin
      verdict_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch("unexpected result, kind", rsp_kind, -1);
         end else begin
            e = pending_verdicts.pop_front();
            if (rsp_kind != e.kind) report_mismatch("kind", rsp_kind, e.kind);
            if (rsp_charge != e.charge) report_mismatch("charge", rsp_charge, e.charge);
            if (rsp_bin_index != e.bin_index)
               report_mismatch("bin_index", rsp_bin_index, e.bin_index);
            if (rsp_bin_count != e.bin_count)
               report_mismatch("bin_count", rsp_bin_count, e.bin_count);
            if (rsp_high_clip_total != e.high_total)
               report_mismatch("high_clip_total", rsp_high_clip_total, e.high_total);
            if (rsp_low_clip_total != e.low_total)
               report_mismatch("low_clip_total", rsp_low_clip_total, e.low_total);
         end
      end
      if (calm) begin
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if ($urandom_range(7) == 0) begin
         stall_left = int'($urandom_range(9, 1));
      end
      rsp_stall <= (stall_left > 0);
   end

   // send one request beat, hold it until taken, then maybe go quiet
   task automatic send_beat(logic [1:0] t, logic [11:0] s, logic last,
                            logic [15:0] dth, logic [11:0] addr);
      req_valid         <= 1'b1;
      req_type          <= t;
      req_sample        <= s;
      req_last_of_trace <= last;
      req_dither        <= dth;
      req_bin_address   <= addr;
      do @(posedge clock); while (req_stall);
      predict_beat(t, s, last, dth, addr);
      beats_sent++;
      if (!calm && $urandom_range(5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(9, 1)) @(posedge clock);
      end
   endtask

   task automatic send_sample(int unsigned s, bit last);
      send_beat(qdc_pkg::REQ_SAMPLE, 12'(s), last, 16'($urandom_range(65535)),
                12'($urandom_range(4095)));
   endtask

   task automatic send_read(int unsigned addr);
      send_beat(qdc_pkg::REQ_READ, 12'($urandom_range(4095)), 1'($urandom_range(1)),
                16'($urandom_range(65535)), 12'(addr));
   endtask

   // wait until every expected result is in and the block is idle again
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0 || req_stall) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // write one register while the block is quiet
   task automatic write_reg(qdc_pkg::reg_index_type idx, int unsigned value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= 22'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      reg_shadow[idx] = 22'(value);
      drop_trace();
      wipe_spectrum();
   endtask

   task automatic set_regs(int unsigned w, int unsigned p, int unsigned mn,
                           int unsigned mx, int unsigned nb);
      write_reg(qdc_pkg::REG_WINDOW, w);
      write_reg(qdc_pkg::REG_BASELINE, p);
      write_reg(qdc_pkg::REG_MIN, mn);
      write_reg(qdc_pkg::REG_MAX, mx);
      write_reg(qdc_pkg::REG_BINS, nb);
   endtask

   // one trace: flat baseline, then a pulse on top, optionally clipped
   task automatic send_trace(int unsigned len, int unsigned level, int unsigned pulse,
                             int unsigned clip_mode);
      int unsigned p, s, clip_at;
      p = clamp(reg_shadow[qdc_pkg::REG_BASELINE], 1, qdc_pkg::MAX_WINDOW);
      clip_at = p + $urandom_range(1);
      for (int i = 0; i < len; i++) begin
         s = level + $urandom_range(3);
         if (i >= p) s = (s + pulse > 4095) ? 4095 : s + pulse;
         if (clip_mode == 1 && (i == clip_at || i == clip_at + 1)) s = 4095;
         if (clip_mode == 2 && (i == clip_at || i == clip_at + 1)) s = 0;
         send_sample(s, i == len - 1);
      end
   endtask

   task automatic test_default_traces();
      send_trace(30, 1000, 3, 0);
      send_trace(30, 0, 0, 0);
      send_trace(30, 4095, 0, 0);
      send_beat(qdc_pkg::REQ_SAMPLE, 12'd0, 1'b1, 16'd0, 12'd0);
      send_beat(qdc_pkg::REQ_SAMPLE, 12'hFFF, 1'b1, 16'hFFFF, 12'hFFF);
   endtask

   task automatic test_clip_verdicts();
      send_trace(30, 500, 10, 1);
      send_trace(30, 500, 10, 2);
      send_trace(30, 100, 4000, 0);
      send_read(0);
      send_read(4095);
   endtask

   task automatic test_read_clear_unused();
      send_read(recent_bin);
      send_beat(qdc_pkg::REQ_NONE, 12'hFFF, 1'b1, 16'hFFFF, 12'hFFF);
      send_sample(700, 0);
      send_beat(qdc_pkg::REQ_CLEAR, 12'd5, 1'b0, 16'd7, 12'd9);
      send_trace(29, 700, 2, 0);
      send_read(recent_bin);
      drain();
   endtask

   task automatic test_short_long_traces();
      set_regs(6, 4, 0, 40, 64);
      send_trace(2, 900, 50, 0);
      send_trace(7, 900, 50, 0);
      send_trace(25, 900, 50, 0);
      send_read(recent_bin);
   endtask

   task automatic test_register_extremes();
      set_regs(0, 0, 0, 0, 0);
      send_trace(3, 1200, 9, 0);
      set_regs(2047, 2047, 4194303, 4194303, 8191);
      send_trace(2, 300, 0, 0);
      set_regs(3, 2, 4194303, 1, 4096);
      send_trace(5, 200, 3000, 0);
      // wide trace running past the end of its window
      set_regs(256, 256, 0, 4194303, 4096);
      send_trace(520, 100, 2000, 0);
      send_read(recent_bin);
   endtask

   task automatic random_phase(int unsigned beats);
      int unsigned stop_at, w, p, roll, len, clip;
      stop_at = beats_sent + beats;
      set_regs($urandom_range(16, 1), $urandom_range(16, 1), $urandom_range(200),
               $urandom_range(70000, 500), $urandom_range(3) == 0 ? $urandom_range(4096, 1)
               : $urandom_range(4096, 64));
      w = reg_shadow[qdc_pkg::REG_WINDOW];
      p = reg_shadow[qdc_pkg::REG_BASELINE];
      while (beats_sent < stop_at) begin
         roll = $urandom_range(99);
         if (roll < 75) begin
            len  = ($urandom_range(9) == 0) ? $urandom_range(p + w + 4, 1) : p + w;
            clip = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : 0;
            send_trace(len, $urandom_range(3000, 50), $urandom_range(4000), clip);
         end else if (roll < 93) begin
            send_read($urandom_range(1) ? recent_bin : $urandom_range(4095));
         end else if (roll < 98) begin
            send_sample($urandom_range(4095), 1'($urandom_range(1)));
         end else if (roll < 99) begin
            send_beat(qdc_pkg::REQ_NONE, 12'($urandom_range(4095)), 1'($urandom_range(1)),
                      16'($urandom_range(65535)), 12'($urandom_range(4095)));
         end else begin
            send_beat(qdc_pkg::REQ_CLEAR, 12'($urandom_range(4095)), 1'($urandom_range(1)),
                      16'($urandom_range(65535)), 12'($urandom_range(4095)));
         end
      end
   endtask

   initial begin
      reg_shadow[qdc_pkg::REG_WINDOW]   = 20;
      reg_shadow[qdc_pkg::REG_BASELINE] = 10;
      reg_shadow[qdc_pkg::REG_MIN]      = 0;
      reg_shadow[qdc_pkg::REG_MAX]      = 100;
      reg_shadow[qdc_pkg::REG_BINS]     = 4096;
      drop_trace();
      wipe_spectrum();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_default_traces();
      test_clip_verdicts();
      test_read_clear_unused();
      test_short_long_traces();
      test_register_extremes();
      // share what is left of the item budget over the random phases
      phase_len = (beats_sent + 60 < ITEM_TARGET) ? (ITEM_TARGET - beats_sent) / 6 : 10;
      for (int k = 0; k < 5; k++) random_phase(phase_len);
      calm = 1'b1;
      random_phase(phase_len);

      drain();
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/qdc_pkg.sv
rtl/qdc_div.sv
rtl/qdc_hist.sv
rtl/qdc_charge_histogram_core.sv
bench/tb_qdc_charge_histogram_core.sv
